[hdl/arfc_pkg.sv]
// Shared types and constants for the average row filter codec.
package arfc_pkg;

  localparam int LINE_BYTES_DEF = 16384;
  localparam int MAX_BPP_DEF    = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WIDTH_W    = 15;
  localparam int BPP_W      = 4;
  localparam int HEIGHT_W   = 16;
  localparam int STRIDE_W   = WIDTH_W + BPP_W;
  localparam int COL_W      = STRIDE_W;
  localparam int BPP_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_BPP    = 3'd2,
    REG_HEIGHT = 3'd3
  } cfg_reg_t;

  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_RECON  = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic                 left_ok;
    logic                 up_ok;
    logic [BPP_IDX_W-1:0] bpp_m1;
    logic                 last;
    logic                 cfg_err;
  } arfc_item_ctl_t;

endpackage

[hdl/arfc_in_if.sv]
// Input byte channel.
interface arfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_byte;

  modport source (output valid, output sample_byte, input ready);
  modport sink (input valid, input sample_byte, output ready);
endinterface

[hdl/arfc_out_if.sv]
// Result byte channel.
interface arfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_image;
  logic       config_error;

  modport source (output valid, output out_byte, output last_of_image,
                  output config_error, input ready);
  modport sink (input valid, input out_byte, input last_of_image,
                input config_error, output ready);
endinterface

[hdl/arfc_cfg_if.sv]
// Configuration write channel.
interface arfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [arfc_pkg::CFG_IDX_W-1:0]  index;
  logic [arfc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/average_row_filter_codec.sv]
// Average predictor filter / reconstruct over a raster byte stream.
// Input is registered in the A stage, the result in the output register.
// Throughput: one item per cycle unless the output stalls; line store read on
// accept, written back on compute, forwarding back-to-back same-entry hits.
// Reset: synchronous active-low; config regs to defaults, counters to zero,
// line store and left history hold no defined value until written.
module average_row_filter_codec #(
  parameter int LINE_BYTES = arfc_pkg::LINE_BYTES_DEF,
  parameter int MAX_BPP    = arfc_pkg::MAX_BPP_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  arfc_cfg_if.sink   cfg_if,
  arfc_in_if.sink    in_if,
  arfc_out_if.source out_if
);
  import arfc_pkg::*;

  localparam int AW      = $clog2(LINE_BYTES);
  localparam int HIST_IW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  arfc_item_ctl_t item_ctl;
  logic [AW-1:0]  rd_addr;

  logic [7:0]     line_mem [LINE_BYTES];
  logic [7:0]     rd_data_r;
  logic [7:0]     hist_r [MAX_BPP];

  logic           a_valid_r;
  arfc_item_ctl_t a_ctl_r;
  logic [7:0]     a_byte_r;
  logic [AW-1:0]  a_addr_r;
  logic           a_fwd_r;
  logic [7:0]     a_fwd_data_r;

  logic           out_valid_r;
  logic [7:0]     out_byte_r;
  logic           out_last_r;
  logic           out_err_r;

  logic           fire_a;
  logic           acc;
  logic [7:0]     up_b;
  logic [7:0]     left_b;
  logic [8:0]     sum;
  logic [7:0]     avg;
  logic [7:0]     res;
  logic [7:0]     keep;

  assign fire_a      = a_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !a_valid_r || fire_a;
  assign acc         = in_if.valid && in_if.ready;

  arfc_ctrl #(
    .LINE_BYTES(LINE_BYTES),
    .MAX_BPP   (MAX_BPP)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_if  (cfg_if),
    .advance (acc),
    .item_ctl(item_ctl),
    .rd_addr (rd_addr)
  );

  always_comb begin
    up_b   = a_ctl_r.up_ok ? (a_fwd_r ? a_fwd_data_r : rd_data_r) : 8'd0;
    left_b = a_ctl_r.left_ok ? hist_r[a_ctl_r.bpp_m1[HIST_IW-1:0]] : 8'd0;
    sum    = {1'b0, up_b} + {1'b0, left_b};
    avg    = sum[8:1];
    if (a_ctl_r.mode == MODE_RECON) begin
      res  = a_byte_r + avg;
      keep = res;
    end else begin
      res  = a_byte_r - avg;
      keep = a_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) rd_data_r <= line_mem[rd_addr];
    if (fire_a) line_mem[a_addr_r] <= keep;
  end

  always_ff @(posedge clk) begin
    if (fire_a) begin
      hist_r[0] <= keep;
      for (int i = 1; i < MAX_BPP; i++) hist_r[i] <= hist_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (acc) begin
      a_valid_r <= 1'b1;
    end else if (fire_a) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_ctl_r      <= item_ctl;
      a_byte_r     <= in_if.sample_byte;
      a_addr_r     <= rd_addr;
      // entry being written this same edge: the read above sees the old byte
      a_fwd_r      <= fire_a && (a_addr_r == rd_addr);
      a_fwd_data_r <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_a) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_a) begin
      out_byte_r <= res;
      out_last_r <= a_ctl_r.last;
      out_err_r  <= a_ctl_r.cfg_err;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.out_byte      = out_byte_r;
  assign out_if.last_of_image = out_last_r;
  assign out_if.config_error  = out_err_r;

endmodule

[hdl/arfc_ctrl.sv]
// Configuration registers and raster position counters.
module arfc_ctrl #(
  parameter int LINE_BYTES = arfc_pkg::LINE_BYTES_DEF,
  parameter int MAX_BPP    = arfc_pkg::MAX_BPP_DEF,
  localparam int AW        = $clog2(LINE_BYTES)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  arfc_cfg_if.sink                 cfg_if,
  input  logic                     advance,
  output arfc_pkg::arfc_item_ctl_t item_ctl,
  output logic [AW-1:0]            rd_addr
);
  import arfc_pkg::*;

  logic                mode_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [BPP_W-1:0]    bpp_r;
  logic [HEIGHT_W-1:0] height_r;

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;

  logic [BPP_W-1:0]    bpp_eff;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [STRIDE_W-1:0] stride;
  logic                end_row;
  logic                end_img;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_FILTER;
      width_r  <= WIDTH_W'(1);
      bpp_r    <= BPP_W'(1);
      height_r <= HEIGHT_W'(1);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_MODE:   mode_r   <= cfg_if.data[0];
        REG_WIDTH:  width_r  <= cfg_if.data[WIDTH_W-1:0];
        REG_BPP:    bpp_r    <= cfg_if.data[BPP_W-1:0];
        REG_HEIGHT: height_r <= cfg_if.data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bpp_eff = bpp_r;
    if (bpp_r == '0) bpp_eff = BPP_W'(1);
    if (bpp_r > BPP_W'(MAX_BPP)) bpp_eff = BPP_W'(MAX_BPP);
    w_eff   = (width_r == '0) ? WIDTH_W'(1) : width_r;
    h_eff   = (height_r == '0) ? HEIGHT_W'(1) : height_r;
    stride  = STRIDE_W'(w_eff) * STRIDE_W'(bpp_eff);
    end_row = ({1'b0, col_r} + (COL_W+1)'(1)) >= {1'b0, stride};
    end_img = end_row && (({1'b0, row_r} + (HEIGHT_W+1)'(1)) >= {1'b0, h_eff});
  end

  always_comb begin
    col_nxt  = col_r + COL_W'(1);
    row_nxt  = row_r;
    addr_nxt = (addr_r == AW'(LINE_BYTES - 1)) ? '0 : addr_r + AW'(1);
    if (end_row) begin
      col_nxt  = '0;
      addr_nxt = '0;
      row_nxt  = end_img ? '0 : row_r + HEIGHT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      addr_r <= '0;
    end else if (advance) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign rd_addr          = addr_r;
  assign item_ctl.mode    = mode_r;
  assign item_ctl.left_ok = col_r >= COL_W'(bpp_eff);
  assign item_ctl.up_ok   = row_r != '0;
  assign item_ctl.bpp_m1  = BPP_IDX_W'(bpp_eff - BPP_W'(1));
  assign item_ctl.last    = end_img;
  assign item_ctl.cfg_err = stride > STRIDE_W'(LINE_BYTES);

endmodule

[hdl/arfc_checker.sv]
// Port-level checker for the average row filter codec, bound to the top level.
module arfc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  logic       in_acc;
  logic       out_acc;
  logic [1:0] inflight_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 2'd0)
    else $error("result item without a pending input item");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r != 2'd3)
    else $error("more than two items held inside the block");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && inflight_r == 2'd0 |-> ##2 out_valid)
    else $error("result item late on an empty pipeline");

endmodule

bind average_row_filter_codec arfc_checker u_arfc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready)
);

[verif/average_row_filter_codec_tb.sv]
// Self-checking bench: a directed table, then random images checked against a predictor.
`timescale 1ns / 100ps

module average_row_filter_codec_tb;
  import arfc_pkg::*;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
    logic       err;
  } coded_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    reg_idx;
    logic [15:0] wdata;
    logic        pinned;
    coded_t      want;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_STARVE} rx_mode_t;

  localparam int N_DIR = 42;
  localparam int RAND_ITEMS = 1200;

  // pinned rows: neighbors are zero, so the byte passes through unchanged
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{ROW_BYTE, REG_MODE,   16'h00,    1'b1, '{8'h00, 1'b1, 1'b0}},
    '{ROW_BYTE, REG_MODE,   16'hFF,    1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{ROW_CFG,  REG_MODE,   16'd1,     1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'hA5,    1'b1, '{8'hA5, 1'b1, 1'b0}},
    '{ROW_CFG,  REG_WIDTH,  16'd0,     1'b0, '0},
    '{ROW_CFG,  REG_BPP,    16'd0,     1'b0, '0},
    '{ROW_CFG,  REG_HEIGHT, 16'd0,     1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h5A,    1'b1, '{8'h5A, 1'b1, 1'b0}},
    '{ROW_CFG,  REG_BPP,    16'd15,    1'b0, '0},
    '{ROW_CFG,  REG_WIDTH,  16'd2049,  1'b0, '0},
    '{ROW_CFG,  REG_HEIGHT, 16'd2,     1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h80,    1'b1, '{8'h80, 1'b0, 1'b1}},
    '{ROW_BYTE, REG_MODE,   16'h7F,    1'b1, '{8'h7F, 1'b0, 1'b1}},
    '{ROW_CFG,  REG_WIDTH,  16'd2048,  1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h01,    1'b1, '{8'h01, 1'b0, 1'b0}},
    '{ROW_CFG,  REG_WIDTH,  16'd2,     1'b0, '0},
    '{ROW_CFG,  REG_BPP,    16'd2,     1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h10,    1'b0, '0},
    '{ROW_CFG,  REG_MODE,   16'd0,     1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'hFF,    1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h00,    1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h33,    1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'hCC,    1'b0, '0},
    '{ROW_CFG,  REG_WIDTH,  16'd16384, 1'b0, '0},
    '{ROW_CFG,  REG_BPP,    16'd1,     1'b0, '0},
    '{ROW_CFG,  REG_HEIGHT, 16'd65535, 1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h00,    1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ROW_BYTE, REG_MODE,   16'hFF,    1'b0, '0},
    '{ROW_CFG,  REG_WIDTH,  16'd32767, 1'b0, '0},
    '{ROW_CFG,  REG_BPP,    16'd8,     1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h55,    1'b1, '{8'h55, 1'b0, 1'b1}},
    '{ROW_CFG,  REG_WIDTH,  16'd1,     1'b0, '0},
    '{ROW_CFG,  REG_BPP,    16'd1,     1'b0, '0},
    '{ROW_CFG,  REG_HEIGHT, 16'd1,     1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h9C,    1'b0, '0},
    '{ROW_CFG,  REG_WIDTH,  16'd2,     1'b0, '0},
    '{ROW_CFG,  REG_HEIGHT, 16'd2,     1'b0, '0},
    '{ROW_CFG,  REG_MODE,   16'd1,     1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h11,    1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h22,    1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h33,    1'b0, '0},
    '{ROW_BYTE, REG_MODE,   16'h44,    1'b0, '0}
  };

  logic clk;
  logic rst_n;

  arfc_cfg_if cfg_bus ();
  arfc_in_if  in_bus ();
  arfc_out_if out_bus ();

  average_row_filter_codec DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_bus),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  // predictor state
  logic        cur_mode   = MODE_FILTER;
  logic [14:0] cur_width  = 15'd1;
  logic [3:0]  cur_bpp    = 4'd1;
  logic [15:0] cur_height = 16'd1;
  logic [7:0]  line_mem [LINE_BYTES_DEF];
  logic [7:0]  left_hist [MAX_BPP_DEF];
  int          col_pos    = 0;
  logic [15:0] row_pos    = '0;

  coded_t   coded_q [$];
  dir_row_t typed_q [$];
  int       mismatches = 0;
  rx_mode_t rx_style   = RX_OPEN;
  int       rx_tick    = 0;

  function automatic int bpp_eff(input logic [3:0] b);
    return (b == 0) ? 1 : (b > MAX_BPP_DEF) ? MAX_BPP_DEF : int'(b);
  endfunction

  function automatic int nonzero(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic coded_t avg_code(input logic [7:0] x);
    int         b_e;
    int         stride;
    int         h_e;
    int         addr;
    logic [7:0] left_b;
    logic [7:0] up_b;
    logic [8:0] sum;
    logic [7:0] keep;
    logic       end_row;
    coded_t     r;
    b_e    = bpp_eff(cur_bpp);
    stride = nonzero(int'(cur_width)) * b_e;
    h_e    = nonzero(int'(cur_height));
    addr   = col_pos % LINE_BYTES_DEF;
    left_b = (col_pos >= b_e) ? left_hist[b_e-1] : 8'h00;
    up_b   = (row_pos != 0) ? line_mem[addr] : 8'h00;
    sum    = {1'b0, left_b} + {1'b0, up_b};
    if (cur_mode == MODE_RECON) begin
      r.val = x + sum[8:1];
      keep  = r.val;
    end else begin
      r.val = x - sum[8:1];
      keep  = x;
    end
    line_mem[addr] = keep;
    for (int k = MAX_BPP_DEF - 1; k > 0; k--) left_hist[k] = left_hist[k-1];
    left_hist[0] = keep;
    end_row = (col_pos + 1 >= stride);
    r.last  = end_row && (int'(row_pos) + 1 >= h_e);
    r.err   = (stride > LINE_BYTES_DEF);
    if (end_row) begin
      col_pos = 0;
      row_pos = r.last ? 16'd0 : row_pos + 16'd1;
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

  // receiver backpressure
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (rx_style)
        RX_OPEN:    out_bus.ready <= 1'b1;
        RX_COIN:    out_bus.ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_bus.ready <= (rx_tick % 7) < 4;
        default:    out_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
      rx_tick++;
    end
  end

  always @(posedge clk) begin
    coded_t   got;
    coded_t   want;
    dir_row_t pin;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_reg_t'(cfg_bus.index))
          REG_MODE:   cur_mode   = cfg_bus.data[0];
          REG_WIDTH:  cur_width  = cfg_bus.data[14:0];
          REG_BPP:    cur_bpp    = cfg_bus.data[3:0];
          REG_HEIGHT: cur_height = cfg_bus.data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        want = avg_code(in_bus.sample_byte);
        if (typed_q.size() != 0) begin
          pin = typed_q.pop_front();
          if (pin.pinned) want = pin.want;
        end
        coded_q = {coded_q, want};
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.out_byte, out_bus.last_of_image, out_bus.config_error};
        if (coded_q.size() == 0) begin
          $display("%0t: unexpected item %02h last %b err %b", $time, got.val, got.last,
                   got.err);
          mismatches++;
        end else begin
          want = coded_q.pop_front();
          if (got.val !== want.val) begin
            $display("%0t: out_byte expected %02h got %02h", $time, want.val, got.val);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_of_image expected %b got %b", $time, want.last, got.last);
            mismatches++;
          end
          if (got.err !== want.err) begin
            $display("%0t: config_error expected %b got %b", $time, want.err, got.err);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    in_bus.valid       <= 1'b1;
    in_bus.sample_byte <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
  endtask

  // stop sending and wait for every outstanding item to come back
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (coded_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int          rand_items;
    int          burst_left;
    int          n;
    int          b_e;
    int          h_e;
    longint      stride;
    longint      row_left;
    longint      img_left;
    longint      img_size;
    bit          gapless;
    logic        nm;
    logic [15:0] nw;
    logic [15:0] nb;
    logic [15:0] nh;
    rand_items = 0;
    burst_left = 0;
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.sample_byte <= 8'h00;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_MODE;
    cfg_bus.data       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    rx_style = RX_COIN;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        if (i == 0 || DIR_TAB[i-1].kind == ROW_BYTE) settle();
        write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].wdata);
        if (i == N_DIR - 1 || DIR_TAB[i+1].kind == ROW_BYTE) cfg_bus.valid <= 1'b0;
      end else begin
        typed_q = {typed_q, DIR_TAB[i]};
        push_byte(DIR_TAB[i].wdata[7:0]);
      end
    end

    while (rand_items < RAND_ITEMS) begin
      settle();
      rx_style = rx_mode_t'($urandom_range(0, 3));
      gapless  = ($urandom_range(0, 3) == 0);
      nm       = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       nh = 16'd0;
        1:       nh = 16'($urandom_range(7, 65535));
        default: nh = 16'($urandom_range(1, 6));
      endcase
      nw = {1'b0, cur_width};
      nb = {12'd0, cur_bpp};
      // row geometry may only change in the first row, so later rows read written entries
      if (row_pos == 0) begin
        case ($urandom_range(0, 9))
          0:       nw = 16'd0;
          1:       nw = 16'($urandom_range(2049, 32767));
          2:       nw = 16'($urandom_range(9, 64));
          default: nw = 16'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
          0:       nb = 16'd0;
          1:       nb = 16'($urandom_range(9, 15));
          default: nb = 16'($urandom_range(1, 8));
        endcase
      end
      write_reg(REG_MODE, {15'd0, nm});
      write_reg(REG_WIDTH, nw);
      write_reg(REG_BPP, nb);
      write_reg(REG_HEIGHT, nh);
      cfg_bus.valid <= 1'b0;

      b_e      = bpp_eff(nb[3:0]);
      h_e      = nonzero(int'(nh));
      stride   = longint'(nonzero(int'(nw[14:0]))) * b_e;
      row_left = (col_pos >= stride) ? 1 : stride - col_pos;
      img_left = (int'(row_pos) + 1 >= h_e) ? row_left
                 : row_left + (h_e - 1 - int'(row_pos)) * stride;
      img_size = stride * h_e;
      if (img_left > 400 || $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 60);
      end else begin
        n = int'(img_left);
        if (img_size <= 200) n += $urandom_range(0, 2) * int'(img_size);
      end

      for (int j = 0; j < n; j++) begin
        if (!gapless && burst_left == 0) begin
          in_bus.valid <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
          burst_left = $urandom_range(1, 16);
        end
        push_byte(8'($urandom_range(0, 255)));
        if (burst_left > 0) burst_left--;
      end
      rand_items += n;
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && coded_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[average_row_filter_codec.f]
hdl/arfc_pkg.sv
hdl/arfc_in_if.sv
hdl/arfc_out_if.sv
hdl/arfc_cfg_if.sv
hdl/arfc_ctrl.sv
hdl/average_row_filter_codec.sv
hdl/arfc_checker.sv
verif/average_row_filter_codec_tb.sv
